FILE: src/mnst_pkg.sv
`timescale 1ns / 1ps
package mnst_pkg;

    localparam int NOTE_W  = 7;
    localparam int VEL_W   = 7;
    localparam int CHAN_W  = 4;
    localparam int MARKS_W = 128;
    localparam int HALF_W  = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [NOTE_W-1:0] DAMPER_CTRL     = 7'd64;
    localparam logic [VEL_W-1:0]  PEDAL_THRESHOLD = 7'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_LISTEN_CHANNEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEDAL_ENABLE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED        = 2'd2;

    typedef enum logic [1:0] {
        ACT_NOTE_OFF = 2'd0,
        ACT_NOTE_ON  = 2'd1,
        ACT_CONTROL  = 2'd2,
        ACT_CLEAR    = 2'd3
    } t_action;

    typedef struct packed {
        t_action            action;
        logic               hit;
        logic               pedal_en;
        logic [NOTE_W-1:0]  number;
        logic [VEL_W-1:0]   value;
    } t_evt;

endpackage

FILE: src/midi_note_sustain_tracker_top.sv
`timescale 1ns / 1ps
// An input transaction passes through the input register and then the result register.
// Throughput: one transaction per cycle unless i_stall holds the output; the note marks
// update as bit vectors and the velocity memory read is issued at input accept with write bypass.
// Reset: synchronous, active low; clears marks, pedal, velocity valid bits and
// configuration (listen channel 0, pedal enabled, block disabled).
module midi_note_sustain_tracker_top #(
    parameter int NUM_NOTES = 128
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [1:0]                      i_action,
    input  logic [mnst_pkg::CHAN_W-1:0]     i_event_channel,
    input  logic [mnst_pkg::NOTE_W-1:0]     i_number,
    input  logic [mnst_pkg::VEL_W-1:0]      i_value,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [mnst_pkg::HALF_W-1:0]     o_sounding_low,
    output logic [mnst_pkg::HALF_W-1:0]     o_sounding_high,
    output logic                            o_pedal_down,
    output logic [mnst_pkg::VEL_W-1:0]      o_note_velocity,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mnst_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mnst_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mnst_pkg::*;

    logic [CHAN_W-1:0]  r_listen;
    logic               r_pedal_en;
    logic               r_enabled;

    logic               r_in_valid;
    t_action            r_in_action;
    logic [CHAN_W-1:0]  r_in_chan;
    logic [NOTE_W-1:0]  r_in_number;
    logic [VEL_W-1:0]   r_in_value;

    logic               r_out_valid;
    logic [MARKS_W-1:0] r_sounding;
    logic               r_pedal;
    logic [VEL_W-1:0]   r_vel;

    logic               w_out_free;
    logic               w_adv;
    logic               w_accept;
    t_evt               w_evt;
    logic [NUM_NOTES-1:0] w_sounding;
    logic               w_pedal;
    logic [VEL_W-1:0]   w_vel;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_listen   <= '0;
            r_pedal_en <= 1'b1;
            r_enabled  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_LISTEN_CHANNEL: r_listen   <= i_cfg_data[CHAN_W-1:0];
                CFG_PEDAL_ENABLE:   r_pedal_en <= i_cfg_data[0];
                CFG_ENABLED:        r_enabled  <= i_cfg_data[0];
                default:            r_listen   <= r_listen;
            endcase
        end
    end

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_adv      = r_in_valid && w_out_free;
    assign o_stall    = r_in_valid && !w_out_free;
    assign w_accept   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_action <= t_action'(i_action);
            r_in_chan   <= i_event_channel;
            r_in_number <= i_number;
            r_in_value  <= i_value;
        end
    end

    always_comb begin
        w_evt.action   = r_in_action;
        w_evt.hit      = r_enabled && (r_in_chan == r_listen);
        w_evt.pedal_en = r_pedal_en;
        w_evt.number   = r_in_number;
        w_evt.value    = r_in_value;
    end

    mnst_note_state #(
        .NUM_NOTES (NUM_NOTES)
    ) u_note_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_evt      (w_evt),
        .o_sounding (w_sounding),
        .o_pedal    (w_pedal)
    );

    mnst_vel_store #(
        .NUM_NOTES (NUM_NOTES)
    ) u_vel_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (w_accept),
        .i_rd_number (i_number),
        .i_adv       (w_adv),
        .i_evt       (w_evt),
        .o_velocity  (w_vel)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sounding <= MARKS_W'(w_sounding);
            r_pedal    <= w_pedal;
            r_vel      <= w_vel;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_sounding_low  = r_sounding[HALF_W-1:0];
    assign o_sounding_high = r_sounding[MARKS_W-1:HALF_W];
    assign o_pedal_down    = r_pedal;
    assign o_note_velocity = r_vel;

    a_adv_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> o_valid)
        else $error("result lost after stage advance");

    a_held_item_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> r_in_valid)
        else $error("stalled input transaction dropped");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_action == ACT_CLEAR) |=>
            (o_sounding_low == '0 && o_sounding_high == '0))
        else $error("clear left sounding notes");

endmodule

FILE: src/mnst_vel_store.sv
`timescale 1ns / 1ps
module mnst_vel_store #(
    parameter int NUM_NOTES = 128
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [mnst_pkg::NOTE_W-1:0] i_rd_number,
    input  logic                        i_adv,
    input  mnst_pkg::t_evt              i_evt,
    output logic [mnst_pkg::VEL_W-1:0]  o_velocity
);
    import mnst_pkg::*;

    localparam int AW = (NUM_NOTES > 1) ? $clog2(NUM_NOTES) : 1;

    logic [VEL_W-1:0]     r_mem [NUM_NOTES];
    logic [NUM_NOTES-1:0] r_valid;
    logic [VEL_W-1:0]     r_rdata;
    logic                 w_note_ok;
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [AW-1:0]        w_raddr;

    assign w_note_ok = ({1'b0, i_evt.number} < (NOTE_W+1)'(NUM_NOTES));
    assign w_we      = i_adv && i_evt.hit && (i_evt.action == ACT_NOTE_ON) && w_note_ok;
    assign w_waddr   = i_evt.number[AW-1:0];
    assign w_raddr   = i_rd_number[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= i_evt.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (w_we && (w_waddr == w_raddr)) begin
                r_rdata <= i_evt.value;
            end else begin
                r_rdata <= r_mem[w_raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_we) begin
            r_valid[w_waddr] <= 1'b1;
        end
    end

    always_comb begin
        if (!w_note_ok) begin
            o_velocity = '0;
        end else if (w_we) begin
            o_velocity = i_evt.value;
        end else if (r_valid[w_waddr]) begin
            o_velocity = r_rdata;
        end else begin
            o_velocity = '0;
        end
    end

endmodule

FILE: src/mnst_note_state.sv
`timescale 1ns / 1ps
module mnst_note_state #(
    parameter int NUM_NOTES = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  mnst_pkg::t_evt       i_evt,
    output logic [NUM_NOTES-1:0] o_sounding,
    output logic                 o_pedal
);
    import mnst_pkg::*;

    logic [NUM_NOTES-1:0] r_pressed;
    logic [NUM_NOTES-1:0] r_sounding;
    logic                 r_pedal;
    logic [NUM_NOTES-1:0] n_pressed;
    logic [NUM_NOTES-1:0] n_sounding;
    logic                 n_pedal;
    logic [NUM_NOTES-1:0] w_mask;

    always_comb begin
        for (int k = 0; k < NUM_NOTES; k++) begin
            w_mask[k] = (i_evt.number == NOTE_W'(k));
        end
    end

    always_comb begin
        n_pressed  = r_pressed;
        n_sounding = r_sounding;
        n_pedal    = r_pedal;
        if (i_evt.action == ACT_CLEAR) begin
            n_pressed  = '0;
            n_sounding = '0;
        end else if (i_evt.hit) begin
            unique case (i_evt.action)
                ACT_NOTE_ON: begin
                    n_pressed  = r_pressed | w_mask;
                    n_sounding = r_sounding | w_mask;
                end
                ACT_NOTE_OFF: begin
                    n_pressed = r_pressed & ~w_mask;
                    if (!r_pedal) begin
                        n_sounding = r_sounding & ~w_mask;
                    end
                end
                ACT_CONTROL: begin
                    if (i_evt.number == DAMPER_CTRL && i_evt.pedal_en) begin
                        n_pedal = (i_evt.value >= PEDAL_THRESHOLD);
                        if (!n_pedal) begin
                            n_sounding = r_sounding & r_pressed;
                        end
                    end
                end
                default: begin
                    n_pressed = r_pressed;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed  <= '0;
            r_sounding <= '0;
            r_pedal    <= 1'b0;
        end else if (i_adv) begin
            r_pressed  <= n_pressed;
            r_sounding <= n_sounding;
            r_pedal    <= n_pedal;
        end
    end

    assign o_sounding = n_sounding;
    assign o_pedal    = n_pedal;

endmodule
